// ===== design/ascii_integer_parser_assert.svh =====
// Assertion macros for the ASCII integer parser.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASCII_INTEGER_PARSER_ASSERT_SVH
`define ASCII_INTEGER_PARSER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define AIP_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Implication checked in the cycle after the condition.
`define AIP_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/aip_pkg.sv =====
// Package for the ASCII integer parser: payload structs, parse state,
// character constants and the digit decode function. No dependencies.
package aip_pkg;

    localparam int VALUE_WIDTH = 32;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_AFTER_SIGN,
        PH_DIGITS,
        PH_STOPPED,
        PH_FAILED
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_TOOBIG   = 2'd2,
        ST_TOOSMALL = 2'd3
    } status_t;

    localparam logic REG_RADIX       = 1'b0;
    localparam logic REG_SIGNED_MODE = 1'b1;

    localparam logic [4:0] RADIX_RESET   = 5'd10;
    localparam logic [4:0] RADIX_MIN     = 5'd2;
    localparam logic [4:0] RADIX_DEC_MAX = 5'd10;
    localparam logic [4:0] RADIX_HEX     = 5'd16;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_LA    = 8'd97;
    localparam logic [7:0] CH_LF    = 8'd102;
    localparam logic [7:0] CH_UA    = 8'd65;
    localparam logic [7:0] CH_UF    = 8'd70;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } char_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        status_t                status;
    } result_t;

    typedef struct packed {
        phase_t                 phase;
        logic [VALUE_WIDTH-1:0] accumulator;
        logic                   negative;
        status_t                outcome;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:       PH_LEAD,
        accumulator: '0,
        negative:    1'b0,
        outcome:     ST_OK
    };

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
    } digit_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic digit_t digit_of(input logic [7:0] c, input logic [4:0] radix);
        digit_t     r;
        logic [7:0] off;
        logic [7:0] low_off;
        logic [7:0] up_off;
        off     = c - CH_ZERO;
        low_off = c - CH_LA + HEX_TEN;
        up_off  = c - CH_UA + HEX_TEN;
        r.ok    = 1'b0;
        r.digit = off[3:0];
        if (radix >= RADIX_MIN && radix <= RADIX_DEC_MAX) begin
            r.ok = (c >= CH_ZERO) && (off < {3'b000, radix});
        end else if (radix == RADIX_HEX) begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                r.ok = 1'b1;
            end else if (c >= CH_LA && c <= CH_LF) begin
                r.ok    = 1'b1;
                r.digit = low_off[3:0];
            end else if (c >= CH_UA && c <= CH_UF) begin
                r.ok    = 1'b1;
                r.digit = up_off[3:0];
            end
        end
        return r;
    endfunction

endpackage

// ===== design/aip_step.sv =====
// One parse step: next parse state for one character and the result it gives.
// Depends on aip_pkg.
module aip_step (
    input  aip_pkg::parse_state_t state,
    input  logic [4:0]            radix,
    input  logic                  signed_mode,
    input  logic [7:0]            char_code,
    output aip_pkg::parse_state_t state_next,
    output aip_pkg::result_t      result
);
    import aip_pkg::*;

    localparam int W = VALUE_WIDTH;
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    digit_t       dg;
    logic [W+4:0] prod;
    logic [W+4:0] sum;
    logic         ovf;
    logic         blank;

    assign dg    = digit_of(char_code, radix);
    assign blank = is_blank(char_code);
    assign prod  = {5'b00000, state.accumulator} * {{W{1'b0}}, radix};
    assign sum   = prod + {{(W+1){1'b0}}, dg.digit};
    assign ovf   = |sum[W+4:W];

    always_comb
    begin
        state_next = state;
        case (state.phase)
            PH_LEAD:
            begin
                if (!blank) begin
                    if (signed_mode && (char_code == CH_PLUS || char_code == CH_MINUS)) begin
                        state_next.negative = (char_code == CH_MINUS);
                        state_next.phase    = PH_AFTER_SIGN;
                    end else if (dg.ok) begin
                        state_next.accumulator = {{(W-4){1'b0}}, dg.digit};
                        state_next.phase       = PH_DIGITS;
                    end else begin
                        state_next.outcome = ST_INVALID;
                        state_next.phase   = PH_FAILED;
                    end
                end
            end
            PH_AFTER_SIGN:
            begin
                if (!blank) begin
                    if (dg.ok) begin
                        state_next.accumulator = {{(W-4){1'b0}}, dg.digit};
                        state_next.phase       = PH_DIGITS;
                    end else begin
                        state_next.outcome = ST_INVALID;
                        state_next.phase   = PH_FAILED;
                    end
                end
            end
            PH_DIGITS:
            begin
                if (!dg.ok) begin
                    state_next.phase = PH_STOPPED;
                end else if (ovf) begin
                    state_next.outcome = ST_TOOBIG;
                    state_next.phase   = PH_FAILED;
                end else begin
                    state_next.accumulator = sum[W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.value  = '0;
        result.status = ST_INVALID;
        if (state_next.phase == PH_DIGITS || state_next.phase == PH_STOPPED) begin
            result.status = ST_OK;
            result.value  = state_next.accumulator;
            if (signed_mode && !state_next.negative) begin
                if (state_next.accumulator > SMAX) begin
                    result.value  = SMAX;
                    result.status = ST_TOOBIG;
                end
            end else if (signed_mode) begin
                if (state_next.accumulator > SMIN) begin
                    result.value  = SMIN;
                    result.status = ST_TOOSMALL;
                end else begin
                    result.value = '0 - state_next.accumulator;
                end
            end
        end else if (state_next.phase == PH_FAILED && state_next.outcome == ST_TOOBIG) begin
            result.status = ST_TOOBIG;
            if (!signed_mode) begin
                result.value = '1;
            end else if (state_next.negative) begin
                result.value  = SMIN;
                result.status = ST_TOOSMALL;
            end else begin
                result.value = SMAX;
            end
        end
    end

endmodule

// ===== design/ascii_integer_parser.sv =====
// ASCII integer parser: one character per transfer, one result per string.
// Timing: a transferred character is held in a register and its step is registered
// when it advances; the result of the last character is offered from that same edge.
// Throughput: one character per cycle while char_stall is low, set by the single multiply-add step.
// Reset: asynchronous, active low; clears parse state and valid flags, sets radix 10, signed.
// Depends on aip_pkg, aip_step and ascii_integer_parser_assert.svh.
`include "ascii_integer_parser_assert.svh"

module ascii_integer_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  logic             cfg_index,
    input  logic [4:0]       cfg_data,
    input  logic             char_valid,
    output logic             char_stall,
    input  aip_pkg::char_t   char_data,
    output logic             result_valid,
    input  logic             result_stall,
    output aip_pkg::result_t result_data
);
    import aip_pkg::*;

    logic [4:0]   radix_reg;
    logic         signed_mode_reg;
    char_t        char_reg;
    logic         char_vld_reg;
    logic         char_vld_next;
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_state;
    result_t      step_result;
    result_t      result_reg;
    logic         result_vld_reg;
    logic         result_vld_next;
    logic         advance;
    logic         take;

    aip_step u_step (
        .state       (state_reg),
        .radix       (radix_reg),
        .signed_mode (signed_mode_reg),
        .char_code   (char_reg.char_code),
        .state_next  (step_state),
        .result      (step_result)
    );

    assign advance = char_vld_reg && (!char_reg.last || !result_vld_reg || !result_stall);
    assign char_stall = char_vld_reg && !advance;
    assign take = char_valid && !char_stall;

    always_comb
    begin
        char_vld_next = char_vld_reg;
        if (take) begin
            char_vld_next = 1'b1;
        end else if (advance) begin
            char_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (advance) begin
            state_next = char_reg.last ? STATE_CLEAR : step_state;
        end
    end

    always_comb
    begin
        result_vld_next = result_vld_reg;
        if (advance && char_reg.last) begin
            result_vld_next = 1'b1;
        end else if (!result_stall) begin
            result_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radix_reg       <= RADIX_RESET;
            signed_mode_reg <= 1'b1;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_RADIX:       radix_reg       <= cfg_data;
                REG_SIGNED_MODE: signed_mode_reg <= cfg_data[0];
                default:         radix_reg       <= radix_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_vld_reg   <= 1'b0;
            result_vld_reg <= 1'b0;
            state_reg      <= STATE_CLEAR;
        end else begin
            char_vld_reg   <= char_vld_next;
            result_vld_reg <= result_vld_next;
            state_reg      <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take) begin
            char_reg <= char_data;
        end
        if (advance && char_reg.last) begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_vld_reg;
    assign result_data  = result_reg;

    `AIP_ASSERT_IMPL(a_result_from_last, result_vld_reg && !$past(result_vld_reg), $past(advance && char_reg.last), "result appeared without a last character")
    `AIP_ASSERT_NEXT(a_clear_after_last, advance && char_reg.last, state_reg.phase == PH_LEAD && state_reg.accumulator == '0, "parse state not cleared after last")
    `AIP_ASSERT_IMPL(a_lead_is_clean, state_reg.phase == PH_LEAD, state_reg.accumulator == '0 && !state_reg.negative && state_reg.outcome == ST_OK, "dirty state in leading phase")

endmodule
